### design/sec_pkg.sv
package sec_pkg;

  localparam int MaxRes     = 3;
  localparam int QueueDepth = 4;
  localparam int PtrW       = $clog2(QueueDepth);
  localparam int CntW       = $clog2(QueueDepth + 1);

  localparam logic [7:0] OP_WRITE = 8'h02;
  localparam logic [7:0] OP_RDSR  = 8'h05;
  localparam logic [7:0] OP_READ  = 8'h03;
  localparam logic [7:0] OP_WREN  = 8'h06;
  localparam logic [7:0] DUMMY    = 8'h00;
  localparam int         WipBit   = 0;

  typedef enum logic [1:0] {
    FUNC_STATUS = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_RX     = 2'd3
  } func_t;

  typedef enum logic {
    KIND_TX    = 1'b0,
    KIND_REPLY = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] tx_byte;
    logic       frame_end;
    logic [7:0] reply_data;
    logic       last;
  } res_t;

  function automatic res_t tx_res(logic [7:0] b, logic fend, logic lst);
    res_t r;
    r.kind       = KIND_TX;
    r.tx_byte    = b;
    r.frame_end  = fend;
    r.reply_data = 8'h00;
    r.last       = lst;
    return r;
  endfunction

  function automatic res_t reply_res(logic [7:0] d);
    res_t r;
    r.kind       = KIND_REPLY;
    r.tx_byte    = 8'h00;
    r.frame_end  = 1'b0;
    r.reply_data = d;
    r.last       = 1'b1;
    return r;
  endfunction

endpackage

### design/spi_eeprom_command_sequencer_unit.sv
// SPI EEPROM command sequencer (master side, 9-bit byte addresses).
// Input channel (in_*): one request per host command (status, write, read) or
// per byte received back from the EEPROM (in_func = FUNC_RX, byte on in_rx_byte). Each
// accepted request updates the sequencer state in the same cycle and pushes
// zero to three results into a four-entry result queue.
// Result channel (out_*): bytes to shift out (out_kind = 0, out_frame_end marks
// select release) and host replies (out_kind = 1); out_last marks the final
// result caused by one request.
// Latency: the first result of a request is presented the cycle after it is
// accepted unless an earlier result is still waiting ahead of it.
// Acceptance: a request is taken whenever at most one result is queued, so
// after a burst of results further requests wait until the queue drains to one
// entry; the four-entry queue sets this limit.
// Stalling the result channel holds the queue head; while more than one
// result is queued, in_stall stays high.
// Reset (rst_n low, synchronous) empties the queue and returns the sequencer
// to idle with no pending command. Commands while busy and received bytes
// while idle are accepted and dropped without results.
module spi_eeprom_command_sequencer_unit
  import sec_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_func,
  input  logic [8:0] in_address,
  input  logic [7:0] in_write_data,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] out_tx_byte,
  output logic       out_frame_end,
  output logic [7:0] out_reply_data,
  output logic       out_last
);

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_STATUS = 6'b000010,
    PH_POLL   = 6'b000100,
    PH_WREN   = 6'b001000,
    PH_WRITE  = 6'b010000,
    PH_READ   = 6'b100000
  } phase_t;

  phase_t     phase_r, phase_nxt;
  func_t      pending_r, pending_nxt;
  logic [8:0] addr_r, addr_nxt;
  logic [7:0] data_r, data_nxt;
  logic [1:0] rx_count_r, rx_count_nxt;

  logic       room;
  logic       accept;
  logic [1:0] push_n;
  res_t       push_res [MaxRes];
  res_t       head;
  logic [1:0] rc;
  logic [7:0] cmd_a8_write, cmd_a8_read;
  func_t      func;

  assign in_stall = !room;
  assign accept   = in_valid && room;
  assign func     = func_t'(in_func);
  assign rc       = rx_count_r + 2'd1;

  // A8 rides in bit 3 of the command byte
  assign cmd_a8_write = OP_WRITE | {4'b0, addr_r[8], 3'b0};
  assign cmd_a8_read  = OP_READ  | {4'b0, addr_r[8], 3'b0};

  always_comb begin
    phase_nxt    = phase_r;
    pending_nxt  = pending_r;
    addr_nxt     = addr_r;
    data_nxt     = data_r;
    rx_count_nxt = rx_count_r;
    push_n       = 2'd0;
    for (int k = 0; k < MaxRes; k++) begin
      push_res[k] = tx_res(DUMMY, 1'b0, 1'b0);
    end

    if (accept) begin
      if (func != FUNC_RX) begin
        if (phase_r == PH_IDLE) begin
          pending_nxt = func;
          if (func == FUNC_STATUS) begin
            phase_nxt = PH_STATUS;
          end else begin
            addr_nxt  = in_address;
            data_nxt  = in_write_data;
            phase_nxt = PH_POLL;
          end
          rx_count_nxt = 2'd0;
          push_res[0]  = tx_res(OP_RDSR, 1'b0, 1'b0);
          push_res[1]  = tx_res(DUMMY, 1'b1, 1'b1);
          push_n       = 2'd2;
        end
      end else begin
        case (phase_r)
          PH_STATUS: begin
            if (rc < 2'd2) begin
              rx_count_nxt = rc;
            end else begin
              phase_nxt    = PH_IDLE;
              rx_count_nxt = 2'd0;
              push_res[0]  = reply_res(in_rx_byte);
              push_n       = 2'd1;
            end
          end
          PH_POLL: begin
            if (rc < 2'd2) begin
              rx_count_nxt = rc;
            end else if (in_rx_byte[WipBit]) begin
              // still busy: poll again
              rx_count_nxt = 2'd0;
              push_res[0]  = tx_res(OP_RDSR, 1'b0, 1'b0);
              push_res[1]  = tx_res(DUMMY, 1'b1, 1'b1);
              push_n       = 2'd2;
            end else if (pending_r == FUNC_WRITE) begin
              rx_count_nxt = 2'd0;
              phase_nxt    = PH_WREN;
              push_res[0]  = tx_res(OP_WREN, 1'b1, 1'b1);
              push_n       = 2'd1;
            end else begin
              rx_count_nxt = 2'd0;
              phase_nxt    = PH_READ;
              push_res[0]  = tx_res(cmd_a8_read, 1'b0, 1'b0);
              push_res[1]  = tx_res(addr_r[7:0], 1'b0, 1'b0);
              push_res[2]  = tx_res(DUMMY, 1'b1, 1'b1);
              push_n       = 2'd3;
            end
          end
          PH_WREN: begin
            phase_nxt    = PH_WRITE;
            rx_count_nxt = 2'd0;
            push_res[0]  = tx_res(cmd_a8_write, 1'b0, 1'b0);
            push_res[1]  = tx_res(addr_r[7:0], 1'b0, 1'b0);
            push_res[2]  = tx_res(data_r, 1'b1, 1'b1);
            push_n       = 2'd3;
          end
          PH_WRITE: begin
            if (rc < 2'd3) begin
              rx_count_nxt = rc;
            end else begin
              phase_nxt    = PH_IDLE;
              rx_count_nxt = 2'd0;
              push_res[0]  = reply_res(8'h00);
              push_n       = 2'd1;
            end
          end
          PH_READ: begin
            if (rc < 2'd3) begin
              rx_count_nxt = rc;
            end else begin
              phase_nxt    = PH_IDLE;
              rx_count_nxt = 2'd0;
              push_res[0]  = reply_res(in_rx_byte);
              push_n       = 2'd1;
            end
          end
          default: begin
            // idle: stray received byte is dropped
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      pending_r  <= FUNC_STATUS;
      addr_r     <= '0;
      data_r     <= '0;
      rx_count_r <= '0;
    end else begin
      phase_r    <= phase_nxt;
      pending_r  <= pending_nxt;
      addr_r     <= addr_nxt;
      data_r     <= data_nxt;
      rx_count_r <= rx_count_nxt;
    end
  end

  sec_result_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_n     (push_n),
    .push_res   (push_res),
    .room       (room),
    .head_valid (out_valid),
    .head       (head),
    .head_stall (out_stall)
  );

  assign out_kind       = head.kind;
  assign out_tx_byte    = head.tx_byte;
  assign out_frame_end  = head.frame_end;
  assign out_reply_data = head.reply_data;
  assign out_last       = head.last;

  a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> rx_count_r == 2'd0)
    else $error("receive count left over in idle");

  a_busy_request_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    accept && func != FUNC_RX && phase_r != PH_IDLE |=> $stable(phase_r) && $stable(addr_r))
    else $error("request taken while busy");

  a_wren_needs_write: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_WREN |-> pending_r == FUNC_WRITE)
    else $error("write enable frame without pending write");

endmodule

### design/sec_result_queue.sv
module sec_result_queue
  import sec_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       push_n,
  input  res_t             push_res [MaxRes],
  output logic             room,
  output logic             head_valid,
  output res_t             head,
  input  logic             head_stall
);

  res_t            mem_r [QueueDepth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r, count_nxt;
  logic            pop;

  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign pop        = head_valid && !head_stall;
  // room for a full burst, judged on registered occupancy only
  assign room       = (count_r <= CntW'(QueueDepth - MaxRes));
  assign count_nxt  = count_r + CntW'(push_n) - CntW'(pop);

  always_ff @(posedge clk) begin
    for (int k = 0; k < MaxRes; k++) begin
      if (push_n > 2'(k)) begin
        mem_r[wr_ptr_r + PtrW'(k)] <= push_res[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PtrW'(push_n);
      rd_ptr_r <= rd_ptr_r + PtrW'(pop);
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_n != 2'd0 |-> ({1'b0, count_r} + (CntW+1)'(push_n)) <= (CntW+1)'(QueueDepth))
    else $error("result queue overflow");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> count_r == $past(count_r) + CntW'($past(push_n)) - CntW'($past(pop)))
    else $error("result queue count mismatch");

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_n == 2'd3 |-> $past(1'b1) && count_r <= CntW'(QueueDepth - MaxRes))
    else $error("burst pushed without room");

endmodule

### tb/tb_spi_eeprom_command_sequencer_unit.sv
module tb_spi_eeprom_command_sequencer_unit;
  import sec_pkg::*;

  localparam int CycleLimit = 100000;
  localparam int LongHold   = 160;
  localparam int PhaseItems = 58;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_STATUS = 6'b000010,
    S_POLL   = 6'b000100,
    S_WREN   = 6'b001000,
    S_WRITE  = 6'b010000,
    S_READ   = 6'b100000
  } seq_state_t;

  typedef struct packed {
    func_t      func;
    logic [8:0] address;
    logic [7:0] write_data;
    logic [7:0] rx_byte;
  } host_item_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid      = 1'b0;
  logic       in_stall;
  logic [1:0] in_func       = FUNC_STATUS;
  logic [8:0] in_address    = '0;
  logic [7:0] in_write_data = '0;
  logic [7:0] in_rx_byte    = '0;
  logic       out_valid;
  logic       out_stall     = 1'b0;
  logic       out_kind;
  logic [7:0] out_tx_byte;
  logic       out_frame_end;
  logic [7:0] out_reply_data;
  logic       out_last;

  spi_eeprom_command_sequencer_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_address     (in_address),
    .in_write_data  (in_write_data),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_tx_byte    (out_tx_byte),
    .out_frame_end  (out_frame_end),
    .out_reply_data (out_reply_data),
    .out_last       (out_last)
  );

  // sequencer model state
  seq_state_t sq_state   = S_IDLE;
  func_t      sq_op      = FUNC_STATUS;
  logic [8:0] sq_addr    = '0;
  logic [7:0] sq_data    = '0;
  logic [1:0] sq_rx_seen = '0;
  res_t       due_results[$];

  host_item_t pending_reqs[$];
  host_item_t cur_item;
  logic       in_offered;

  int snd_idle_pct  = 0;
  int rcv_stall_pct = 0;
  int noise_pct     = 0;
  int hold_asked    = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  int errors       = 0;
  int cycles       = 0;
  int items_queued = 0;
  int sent_cnt     = 0;
  int taken_cnt    = 0;
  int ignored_cnt  = 0;
  int repoll_cnt   = 0;
  int checked_cnt  = 0;
  int reply_cnt    = 0;

  // a request is on offer until the sampling side has taken it
  assign in_offered = (sent_cnt != taken_cnt);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void push_tx(logic [7:0] b, logic fend, logic lst);
    res_t r;
    r.kind       = KIND_TX;
    r.tx_byte    = b;
    r.frame_end  = fend;
    r.reply_data = 8'h00;
    r.last       = lst;
    due_results.push_back(r);
  endfunction

  function automatic void push_reply(logic [7:0] d);
    res_t r;
    r.kind       = KIND_REPLY;
    r.tx_byte    = 8'h00;
    r.frame_end  = 1'b0;
    r.reply_data = d;
    r.last       = 1'b1;
    due_results.push_back(r);
  endfunction

  function automatic void start_poll();
    sq_rx_seen = 2'd0;
    push_tx(OP_RDSR, 1'b0, 1'b0);
    push_tx(DUMMY, 1'b1, 1'b1);
  endfunction

  // A8 travels in bit 3 of the command byte
  function automatic logic [7:0] with_a8(logic [7:0] op);
    return op | {4'b0000, sq_addr[8], 3'b000};
  endfunction

  function automatic void advance_sequencer(host_item_t it);
    if (it.func != FUNC_RX) begin
      if (sq_state != S_IDLE) begin
        ignored_cnt++;
        return;
      end
      sq_op = it.func;
      if (it.func == FUNC_STATUS) begin
        sq_state = S_STATUS;
      end else begin
        sq_addr  = it.address;
        sq_data  = it.write_data;
        sq_state = S_POLL;
      end
      start_poll();
      return;
    end
    if (sq_state == S_IDLE) begin
      ignored_cnt++;
      return;
    end
    sq_rx_seen = sq_rx_seen + 2'd1;
    case (sq_state)
      S_STATUS: begin
        if (sq_rx_seen >= 2'd2) begin
          sq_state   = S_IDLE;
          sq_rx_seen = 2'd0;
          push_reply(it.rx_byte);
        end
      end
      S_POLL: begin
        if (sq_rx_seen >= 2'd2) begin
          if (it.rx_byte[WipBit]) begin
            repoll_cnt++;
            start_poll();
          end else begin
            sq_rx_seen = 2'd0;
            if (sq_op == FUNC_WRITE) begin
              sq_state = S_WREN;
              push_tx(OP_WREN, 1'b1, 1'b1);
            end else begin
              sq_state = S_READ;
              push_tx(with_a8(OP_READ), 1'b0, 1'b0);
              push_tx(sq_addr[7:0], 1'b0, 1'b0);
              push_tx(DUMMY, 1'b1, 1'b1);
            end
          end
        end
      end
      S_WREN: begin
        sq_state   = S_WRITE;
        sq_rx_seen = 2'd0;
        push_tx(with_a8(OP_WRITE), 1'b0, 1'b0);
        push_tx(sq_addr[7:0], 1'b0, 1'b0);
        push_tx(sq_data, 1'b1, 1'b1);
      end
      S_WRITE: begin
        if (sq_rx_seen >= 2'd3) begin
          sq_state   = S_IDLE;
          sq_rx_seen = 2'd0;
          push_reply(8'h00);
        end
      end
      default: begin
        if (sq_rx_seen >= 2'd3) begin
          sq_state   = S_IDLE;
          sq_rx_seen = 2'd0;
          push_reply(it.rx_byte);
        end
      end
    endcase
  endfunction

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [8:0] rnd_addr();
    return 9'($urandom_range(511));
  endfunction

  function automatic void add_item(func_t f, logic [8:0] a, logic [7:0] d, logic [7:0] rx);
    host_item_t it;
    it.func       = f;
    it.address    = a;
    it.write_data = d;
    it.rx_byte    = rx;
    pending_reqs.push_back(it);
    items_queued++;
  endfunction

  // received byte, now and then preceded by a stray request, dropped if the sequencer is busy
  function automatic void add_rx(logic [7:0] rx);
    if ($urandom_range(99) < noise_pct)
      add_item(func_t'($urandom_range(2)), rnd_addr(), rnd8(), rnd8());
    add_item(FUNC_RX, rnd_addr(), rnd8(), rx);
  endfunction

  function automatic void add_polls(int nbusy);
    for (int i = 0; i < nbusy; i++) begin
      add_rx(rnd8());
      add_rx(rnd8() | 8'h01);
    end
    add_rx(rnd8());
    add_rx(rnd8() & 8'hFE);
  endfunction

  function automatic void add_transaction();
    int   pick;
    int   nbusy;
    logic broken;
    pick   = $urandom_range(99);
    nbusy  = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0;
    broken = ($urandom_range(24) == 0);
    if (pick < 28) begin
      add_item(FUNC_STATUS, rnd_addr(), rnd8(), rnd8());
      add_rx(rnd8());
      if (!broken)
        add_rx(rnd8());
    end else if (pick < 58) begin
      add_item(FUNC_WRITE, rnd_addr(), rnd8(), rnd8());
      add_polls(nbusy);
      if (broken)
        return;
      add_rx(rnd8());
      repeat (3) add_rx(rnd8());
    end else if (pick < 88) begin
      add_item(FUNC_READ, rnd_addr(), rnd8(), rnd8());
      add_polls(nbusy);
      if (broken)
        return;
      repeat (3) add_rx(rnd8());
    end else begin
      add_item(func_t'($urandom_range(3)), rnd_addr(), rnd8(), rnd8());
    end
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_offered || due_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_phase(int snd_pct, int rcv_pct, logic with_hold);
    int target;
    snd_idle_pct  = snd_pct;
    rcv_stall_pct = rcv_pct;
    if (with_hold)
      hold_asked++;
    target = items_queued + PhaseItems;
    while (items_queued < target)
      add_transaction();
    wait_drained();
  endtask

  // request driver
  always @(negedge clk) begin : request_drive
    host_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_offered) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        nxt = pending_reqs.pop_front();
        in_func       <= nxt.func;
        in_address    <= nxt.address;
        in_write_data <= nxt.write_data;
        in_rx_byte    <= nxt.rx_byte;
        in_valid      <= 1'b1;
        cur_item      <= nxt;
        sent_cnt++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : request_take
    if (rst_n && in_valid && in_stall === 1'b0) begin
      advance_sequencer(cur_item);
      taken_cnt++;
    end
  end

  // result side back-pressure; long hold-off counted here
  always @(negedge clk) begin : result_stall
    if (hold_served != hold_asked) begin
      hold_left   = LongHold;
      hold_served = hold_asked;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got.kind       = kind_t'(out_kind);
      got.tx_byte    = out_tx_byte;
      got.frame_end  = out_frame_end;
      got.reply_data = out_reply_data;
      got.last       = out_last;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind=%0d tx=%h fend=%0d reply=%h last=%0d",
                 $time, got.kind, got.tx_byte, got.frame_end, got.reply_data, got.last);
      end else begin
        want = due_results.pop_front();
        checked_cnt++;
        if (want.kind == KIND_REPLY)
          reply_cnt++;
        if (got !== want) begin
          errors++;
          $display("%0t: expected kind=%0d tx=%h fend=%0d reply=%h last=%0d",
                   $time, want.kind, want.tx_byte, want.frame_end, want.reply_data,
                   want.last);
          $display("%0t:   actual kind=%0d tx=%h fend=%0d reply=%h last=%0d",
                   $time, got.kind, got.tx_byte, got.frame_end, got.reply_data, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_spi_eeprom_command_sequencer_unit: errors");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: idle rx byte, status with busy request, write with one busy poll,
    // reads with address bit 8 clear and set
    add_item(FUNC_RX, 9'h1FF, 8'hFF, 8'hFF);
    add_item(FUNC_STATUS, 9'h1FF, 8'hFF, 8'hFF);
    add_item(FUNC_RX, 9'h000, 8'h00, 8'h00);
    add_item(FUNC_READ, 9'h1FF, 8'hFF, 8'h00);
    add_item(FUNC_RX, 9'h000, 8'h00, 8'hFF);
    add_item(FUNC_WRITE, 9'h1FF, 8'hFF, 8'h00);
    add_item(FUNC_RX, 9'h000, 8'h00, 8'h00);
    add_item(FUNC_RX, 9'h000, 8'h00, 8'h01);
    add_item(FUNC_RX, 9'h000, 8'h00, 8'hFF);
    add_item(FUNC_RX, 9'h000, 8'h00, 8'hFE);
    add_item(FUNC_RX, 9'h000, 8'h00, 8'h00);
    add_item(FUNC_RX, 9'h000, 8'h00, 8'h00);
    add_item(FUNC_RX, 9'h000, 8'h00, 8'hFF);
    add_item(FUNC_RX, 9'h000, 8'h00, 8'h00);
    add_item(FUNC_READ, 9'h000, 8'h00, 8'h00);
    add_item(FUNC_RX, 9'h000, 8'h00, 8'h00);
    add_item(FUNC_RX, 9'h000, 8'h00, 8'h00);
    add_item(FUNC_RX, 9'h000, 8'h00, 8'h00);
    add_item(FUNC_RX, 9'h000, 8'h00, 8'h00);
    add_item(FUNC_RX, 9'h000, 8'h00, 8'h00);
    add_item(FUNC_READ, 9'h100, 8'h00, 8'h00);
    add_item(FUNC_RX, 9'h000, 8'h00, 8'h00);
    add_item(FUNC_RX, 9'h000, 8'h00, 8'h00);
    add_item(FUNC_RX, 9'h000, 8'h00, 8'h00);
    add_item(FUNC_RX, 9'h000, 8'h00, 8'h00);
    add_item(FUNC_RX, 9'h000, 8'h00, 8'hA5);
    wait_drained();

    noise_pct = 5;
    run_phase(0, 0, 1'b0);
    run_phase(61, 0, 1'b0);
    run_phase(0, 61, 1'b0);
    run_phase(24, 24, 1'b0);
    run_phase(0, 0, 1'b1);

    repeat (10) @(posedge clk);
    if (due_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, due_results.size());
    end
    $display("run covered %0d requests taken (%0d dropped), %0d write-busy re-polls,",
             taken_cnt, ignored_cnt, repoll_cnt);
    $display("  %0d results checked of which %0d host replies", checked_cnt, reply_cnt);
    if (errors == 0 && due_results.size() == 0) begin
      $display("tb_spi_eeprom_command_sequencer_unit: clean");
    end else begin
      $display("tb_spi_eeprom_command_sequencer_unit: errors");
    end
    $finish;
  end

endmodule
